// ===== hw/rtl/sound_command_mailbox_queue_macros.svh =====
// Assertion macros for the sound command mailbox queue.
// SCMQ_ASSERT_SAME checks the consequent in the same cycle,
// SCMQ_ASSERT_NEXT checks it in the next cycle.
`ifndef SOUND_COMMAND_MAILBOX_QUEUE_MACROS_SVH
`define SOUND_COMMAND_MAILBOX_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define SCMQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCMQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SCMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/scmq_pkg.sv =====
package scmq_pkg;

    // Queue and effect table sizes
    localparam int QUEUE_DEPTH = 8;
    localparam int SFX_SLOTS   = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int CMD_W       = 8;
    localparam int OUT_W       = 7;
    localparam int MASK_W      = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // Constants
    localparam logic [CMD_W-1:0] CMD_LOW_MASK     = 8'h3F;
    localparam logic [CMD_W-1:0] TOGGLE_MARK      = 8'h40;
    localparam logic [CMD_W-1:0] LAST_MUSIC_RESET = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SFX_COMMANDS = 2'd0,
        REG_MUSIC_BASE   = 2'd1,
        REG_MUSIC_STOP   = 2'd2
    } cfg_reg_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic push_music;
        logic push_sfx;
        logic read;
        logic pop;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic nonempty;
    } dp_status_t;

endpackage

// ===== hw/rtl/scmq_ram.sv =====
module scmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/scmq_ctrl.sv =====
`include "sound_command_mailbox_queue_macros.svh"

module scmq_ctrl
    import scmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       strobe,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUSIC,
        S_SFX,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   strobe_reg, strobe_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MUSIC;
                end
            end
            S_MUSIC: state_next = S_SFX;
            S_SFX:   state_next = S_READ;
            S_READ:
            begin
                state_next = status.nonempty ? S_EMIT : S_IDLE;
            end
            S_EMIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        busy_next   = (state_next != S_IDLE);
        strobe_next = (state_next == S_EMIT);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            strobe_reg <= strobe_next;
        end
    end

    // Datapath commands
    always_comb
    begin
        cmd.capture    = (state_reg == S_IDLE) && start;
        cmd.push_music = (state_reg == S_MUSIC);
        cmd.push_sfx   = (state_reg == S_SFX);
        cmd.read       = (state_reg == S_READ) && status.nonempty;
        cmd.pop        = (state_reg == S_EMIT);
    end

    assign busy   = busy_reg;
    assign strobe = strobe_reg;

    // Checks
    `SCMQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy_reg, busy_reg, "busy not raised")
    `SCMQ_ASSERT_NEXT(a_strobe_single, clk, rst_n, strobe_reg, !strobe_reg, "strobe held")

endmodule

// ===== hw/rtl/scmq_datapath.sv =====
`include "sound_command_mailbox_queue_macros.svh"

module scmq_datapath
    import scmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 playing,
    input  logic [CMD_W-1:0]     level_music,
    input  logic [MASK_W-1:0]    sfx_mask,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output logic [OUT_W-1:0]     port_byte
);

    logic [CFG_W-1:0]  sfx_commands_reg;
    logic [CMD_W-1:0]  music_base_reg;
    logic [CMD_W-1:0]  music_stop_reg;

    logic              playing_reg;
    logic [CMD_W-1:0]  level_music_reg;
    logic [MASK_W-1:0] sfx_mask_reg;

    logic [PTR_W-1:0]  read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0]  write_ptr_reg, write_ptr_next;
    logic              toggle_reg;
    logic [CMD_W-1:0]  last_music_reg;

    logic [CMD_W-1:0]  music_eff;
    logic              music_changed;
    logic [CMD_W-1:0]  music_cmd;
    logic              sfx_found;
    logic [CMD_W-1:0]  sfx_cmd;
    logic              ring_full;
    logic              ram_we;
    logic [CMD_W-1:0]  ram_wdata;
    logic [CMD_W-1:0]  ram_rdata;
    logic              toggle_new;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sfx_commands_reg <= '0;
            music_base_reg   <= '0;
            music_stop_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SFX_COMMANDS: sfx_commands_reg <= cfg_data;
                REG_MUSIC_BASE:   music_base_reg   <= cfg_data[CMD_W-1:0];
                REG_MUSIC_STOP:   music_stop_reg   <= cfg_data[CMD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            playing_reg     <= playing;
            level_music_reg <= level_music;
            sfx_mask_reg    <= sfx_mask;
        end
    end

    // Music change detection
    assign music_eff     = playing_reg ? level_music_reg : '0;
    assign music_changed = (music_eff != last_music_reg);
    assign music_cmd     = (music_eff != '0) ? (music_base_reg + music_eff - CMD_W'(1))
                                             : music_stop_reg;

    // Lowest requested slot with a nonzero command
    always_comb
    begin
        sfx_found = 1'b0;
        sfx_cmd   = '0;
        for (int i = 0; i < SFX_SLOTS; i++)
        begin
            if (!sfx_found && sfx_mask_reg[i] && (sfx_commands_reg[CMD_W*i +: CMD_W] != '0))
            begin
                sfx_found = 1'b1;
                sfx_cmd   = sfx_commands_reg[CMD_W*i +: CMD_W];
            end
        end
    end

    // Ring write side; one push per cycle, dropped when full
    assign ring_full = (ring_next(write_ptr_reg) == read_ptr_reg);
    assign ram_we    = !ring_full && ((cmd.push_music && music_changed)
                                      || (cmd.push_sfx && sfx_found));
    assign ram_wdata = cmd.push_music ? music_cmd : sfx_cmd;

    assign write_ptr_next  = ram_we ? ring_next(write_ptr_reg) : write_ptr_reg;
    assign read_ptr_next   = cmd.pop ? ring_next(read_ptr_reg) : read_ptr_reg;
    assign status.nonempty = (read_ptr_reg != write_ptr_reg);

    // Queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_ptr_reg   <= '0;
            write_ptr_reg  <= '0;
            toggle_reg     <= 1'b0;
            last_music_reg <= LAST_MUSIC_RESET;
        end
        else
        begin
            read_ptr_reg  <= read_ptr_next;
            write_ptr_reg <= write_ptr_next;
            if (cmd.pop)
            begin
                toggle_reg <= toggle_new;
            end
            if (cmd.push_music && music_changed)
            begin
                last_music_reg <= music_eff;
            end
        end
    end

    scmq_ram #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (write_ptr_reg),
        .wr_data (ram_wdata),
        .re      (cmd.read),
        .rd_addr (read_ptr_reg),
        .rd_data (ram_rdata)
    );

    // Output byte: low six bits and the toggled mark
    assign toggle_new = ~toggle_reg;
    assign port_byte  = OUT_W'((ram_rdata & CMD_LOW_MASK) | (toggle_new ? TOGGLE_MARK : '0));

    // Checks
    `SCMQ_ASSERT_SAME(a_no_push_full, clk, rst_n, ram_we, !ring_full, "push into full ring")
    `SCMQ_ASSERT_SAME(a_pop_nonempty, clk, rst_n, cmd.pop, status.nonempty, "pop from empty ring")

endmodule

// ===== hw/rtl/sound_command_mailbox_queue.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------
// item in  | start && !busy     | playing, level_music, sfx_mask
// result   | strobe (1 cycle)   | port_byte
// config   | cfg_we             | cfg_index, cfg_data
//
// An item passes from acceptance through a music push, an effect push and a
// registered read to the strobe, or ends with no strobe if the queue is empty;
// busy is high meanwhile, so no new item is taken until it is done. Each possible
// push has its own state in the sequencer, as the ring has a single write port.
// Reset (rst_n low) empties the queue, clears the toggle and the configuration registers.
// The result is shown for one cycle and cannot be stalled.
module sound_command_mailbox_queue
    import scmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 playing,
    input  logic [CMD_W-1:0]     level_music,
    input  logic [MASK_W-1:0]    sfx_mask,
    output logic                 strobe,
    output logic [OUT_W-1:0]     port_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequencer
    scmq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .strobe (strobe),
        .cmd    (dp_cmd),
        .status (dp_status)
    );

    // Queue, registers and command selection
    scmq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .playing     (playing),
        .level_music (level_music),
        .sfx_mask    (sfx_mask),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .port_byte   (port_byte)
    );

endmodule
